@@ rtl/montgomery_reduce_384_assert.svh @@
// Assertion macros for the Montgomery reduction block
`ifndef MONTGOMERY_REDUCE_384_ASSERT_SVH
`define MONTGOMERY_REDUCE_384_ASSERT_SVH
`define MR_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("assertion failed");
`define MR_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/mr384_pkg.sv @@
// Package: types and constants for the BLS12-381 Montgomery reduction
package mr384_pkg;
    localparam int WordW = 64;
    localparam int NumWords = 6;
    localparam logic [63:0] PInv = 64'h89f3fffcfffcfffd;
    localparam logic [383:0] ModP = {
        64'h1a0111ea397fe69a, 64'h4b1ba7b6434bacd7, 64'h64774b84f38512bf,
        64'h6730d2a0f6b0f624, 64'h1eabfffeb153ffff, 64'hb9feffffffffaaab};

    typedef struct packed {
        logic [63:0] in_word_11;
        logic [63:0] in_word_10;
        logic [63:0] in_word_9;
        logic [63:0] in_word_8;
        logic [63:0] in_word_7;
        logic [63:0] in_word_6;
        logic [63:0] in_word_5;
        logic [63:0] in_word_4;
        logic [63:0] in_word_3;
        logic [63:0] in_word_2;
        logic [63:0] in_word_1;
        logic [63:0] in_word_0;
    } mr_in_t;

    typedef struct packed {
        logic [63:0] out_word_5;
        logic [63:0] out_word_4;
        logic [63:0] out_word_3;
        logic [63:0] out_word_2;
        logic [63:0] out_word_1;
        logic [63:0] out_word_0;
    } mr_out_t;
endpackage

@@ rtl/mr384_round.sv @@
// One reduction round: quotient, word products and carry resolve over seven stages
module mr384_round #(
    parameter int Round = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [767:0] in_acc,
    input  logic         in_top,
    output logic         out_valid,
    output logic [767:0] out_acc,
    output logic         out_top
);
    import mr384_pkg::*;

    // one valid bit per stage
    logic [6:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    // stage 1: quotient partial products, 32x32 each
    logic [63:0]  x_word;
    logic [767:0] acc1_reg;
    logic         top1_reg;
    logic [63:0]  q00_reg;
    logic [31:0]  q01_reg;
    logic [31:0]  q10_reg;

    assign x_word = in_acc[Round*64 +: 64];

    // stage 2: quotient word, only the low 64 bits are needed
    logic [767:0] acc2_reg;
    logic         top2_reg;
    logic [63:0]  k_reg;
    logic [63:0]  k_next;

    assign k_next = q00_reg + {q01_reg + q10_reg, 32'd0};

    // stage 3: 32x32 partial products of k and each modulus word
    logic [767:0] acc3_reg;
    logic         top3_reg;
    logic [63:0]  pp_reg [NumWords][4];

    // stage 4: full 128-bit word products
    logic [767:0] acc4_reg;
    logic         top4_reg;
    logic [127:0] prod_reg [NumWords];
    logic [127:0] prod_next [NumWords];

    always_comb begin
        for (int j = 0; j < NumWords; j++) begin
            prod_next[j] = 128'(pp_reg[j][0]) + (128'(pp_reg[j][1]) << 32)
                         + (128'(pp_reg[j][2]) << 32) + {pp_reg[j][3], 64'd0};
        end
    end

    // stage 5: per-word column sums over the seven-word window
    logic [767:0] acc5_reg;
    logic [65:0]  lane_reg [NumWords+1];
    logic [65:0]  lane_next [NumWords+1];

    always_comb begin
        lane_next[0] = 66'(acc4_reg[Round*64 +: 64]) + 66'(prod_reg[0][63:0]);
        for (int t = 1; t < NumWords; t++) begin
            lane_next[t] = 66'(acc4_reg[(Round+t)*64 +: 64]) + 66'(prod_reg[t][63:0])
                         + 66'(prod_reg[t-1][127:64]);
        end
        lane_next[NumWords] = 66'(acc4_reg[(Round+NumWords)*64 +: 64])
                            + 66'(prod_reg[NumWords-1][127:64]) + 66'(top4_reg);
    end

    // stage 6: fold column carries one word up; each word then owes at most one
    logic [767:0]      acc6_reg;
    logic [63:0]       word_reg [NumWords+1];
    logic [NumWords:0] inc_reg;
    logic              topc_reg;
    logic [64:0]       r_next [NumWords+1];
    logic [NumWords:0] inc_next;
    logic              topc_next;

    always_comb begin
        r_next[0] = 65'(lane_reg[0][63:0]);
        for (int t = 1; t <= NumWords; t++) begin
            r_next[t] = 65'(lane_reg[t][63:0]) + 65'(lane_reg[t-1][65:64]);
        end
        inc_next[0] = 1'b0;
        for (int t = 1; t <= NumWords; t++) begin
            inc_next[t] = r_next[t-1][64];
        end
        topc_next = lane_reg[NumWords][64] | r_next[NumWords][64];
    end

    // stage 7: one-bit carry lookahead across the words, then increment
    logic [767:0]        acc7_reg;
    logic                top7_reg;
    logic [767:0]        acc_next;
    logic [NumWords+1:0] cy;

    always_comb begin
        acc_next = acc6_reg;
        cy[0] = 1'b0;
        for (int t = 0; t <= NumWords; t++) begin
            cy[t+1] = (&word_reg[t]) & (inc_reg[t] | cy[t]);
            acc_next[(Round+t)*64 +: 64] = word_reg[t] + 64'(inc_reg[t]) + 64'(cy[t]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc1_reg <= in_acc;
            top1_reg <= in_top;
            q00_reg  <= 64'(x_word[31:0]) * 64'(PInv[31:0]);
            q01_reg  <= 32'(x_word[31:0] * PInv[63:32]);
            q10_reg  <= 32'(x_word[63:32] * PInv[31:0]);

            acc2_reg <= acc1_reg;
            top2_reg <= top1_reg;
            k_reg    <= k_next;

            acc3_reg <= acc2_reg;
            top3_reg <= top2_reg;
            for (int j = 0; j < NumWords; j++) begin
                pp_reg[j][0] <= 64'(k_reg[31:0]) * 64'(ModP[j*64 +: 32]);
                pp_reg[j][1] <= 64'(k_reg[31:0]) * 64'(ModP[j*64+32 +: 32]);
                pp_reg[j][2] <= 64'(k_reg[63:32]) * 64'(ModP[j*64 +: 32]);
                pp_reg[j][3] <= 64'(k_reg[63:32]) * 64'(ModP[j*64+32 +: 32]);
            end

            acc4_reg <= acc3_reg;
            top4_reg <= top3_reg;
            for (int j = 0; j < NumWords; j++) begin
                prod_reg[j] <= prod_next[j];
            end

            acc5_reg <= acc4_reg;
            for (int t = 0; t <= NumWords; t++) begin
                lane_reg[t] <= lane_next[t];
            end

            acc6_reg <= acc5_reg;
            for (int t = 0; t <= NumWords; t++) begin
                word_reg[t] <= r_next[t][63:0];
            end
            inc_reg  <= inc_next;
            topc_reg <= topc_next;

            acc7_reg <= acc_next;
            top7_reg <= topc_reg | cy[NumWords+1];
        end
    end

    assign out_valid = vld_reg[6];
    assign out_acc   = acc7_reg;
    assign out_top   = top7_reg;
endmodule

@@ rtl/montgomery_reduce_384.sv @@
// Top level: pipelined 768-to-384-bit Montgomery reduction, BLS12-381 base field
// Pipeline: 7 stages per round, 2 final stages between input transfer and result valid.
// Throughput: one item per cycle; all stages advance together when the output
// register is free or being drained.
// Reset: synchronous active-low aresetn clears all stage valid bits.
module montgomery_reduce_384 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mr384_pkg::mr_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mr384_pkg::mr_out_t m_data
);
    import mr384_pkg::*;

    logic         adv;
    logic         v   [NumWords+1];
    logic [767:0] acc [NumWords+1];
    logic         top [NumWords+1];

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign v[0]    = s_valid;
    assign acc[0]  = s_data;
    assign top[0]  = 1'b0;

    for (genvar r = 0; r < NumWords; r++) begin : g_round
        mr384_round #(.Round(r)) u_round (
            .aclk(aclk), .aresetn(aresetn), .adv(adv),
            .in_valid(v[r]), .in_acc(acc[r]), .in_top(top[r]),
            .out_valid(v[r+1]), .out_acc(acc[r+1]), .out_top(top[r+1])
        );
    end

    // final conditional subtraction; top carry dropped
    logic [383:0] a_val;
    assign a_val = acc[NumWords][767:384];

    // first stage: per-word differences, borrow and equal flags
    logic                fv_reg;
    logic [383:0]        fa_reg;
    logic [63:0]         fd_reg [NumWords];
    logic [NumWords-1:0] fb_reg;
    logic [NumWords-1:0] fe_reg;
    logic [64:0]         fd_next [NumWords];

    always_comb begin
        for (int t = 0; t < NumWords; t++) begin
            fd_next[t] = {1'b0, a_val[t*64 +: 64]} - {1'b0, ModP[t*64 +: 64]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (adv) begin
            fv_reg <= v[NumWords] && (top[NumWords] || !top[NumWords]);
        end
        if (adv) begin
            fa_reg <= a_val;
            for (int t = 0; t < NumWords; t++) begin
                fd_reg[t] <= fd_next[t][63:0];
                fb_reg[t] <= fd_next[t][64];
                fe_reg[t] <= (a_val[t*64 +: 64] == ModP[t*64 +: 64]);
            end
        end
    end

    // second stage: borrow lookahead across the words, then select
    logic [NumWords:0] bw;
    logic [383:0]      diff;

    always_comb begin
        bw[0] = 1'b0;
        for (int t = 0; t < NumWords; t++) begin
            diff[t*64 +: 64] = fd_reg[t] - 64'(bw[t]);
            bw[t+1] = fb_reg[t] | (fe_reg[t] & bw[t]);
        end
    end

    logic    valid_reg;
    mr_out_t data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= fv_reg;
        end
        if (adv) begin
            data_reg <= bw[NumWords] ? fa_reg : diff;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;
endmodule

@@ rtl/mr384_checker.sv @@
// Port-level checker for montgomery_reduce_384, with bind
`include "montgomery_reduce_384_assert.svh"
module mr384_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input mr384_pkg::mr_out_t m_data
);
    `MR_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `MR_ASSERT_IMPL(a_rdy, !m_valid, s_ready)
    `MR_ASSERT_IMPL(a_stall, m_valid && !m_ready, !s_ready)
endmodule

bind montgomery_reduce_384 mr384_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
